// ----- hdl/mhp_pkg.sv -----
`timescale 1ns / 1ps

package mhp_pkg;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int BODY_DEPTH = 20;

	localparam logic [LEN_W-1:0] BODY_GLOBAL   = 5'd20;
	localparam logic [LEN_W-1:0] BODY_FULL     = 5'd12;
	localparam logic [LEN_W-1:0] BODY_SHORT    = 5'd8;
	localparam logic [LEN_W-1:0] BODY_DST_ONLY = 5'd2;
	localparam logic [LEN_W-1:0] MAX_COUNT     = BODY_GLOBAL + 5'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_DST_ONLY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTRA_ZONE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_ID   = 3'd3;

	typedef enum logic [2:0] {
		LAY_DST_ONLY,
		LAY_GLOBAL,
		LAY_SHORT,
		LAY_FULL,
		LAY_LOCAL
	} lay_t;

	typedef logic [BODY_DEPTH-1:0][BYTE_W-1:0] body_t;

	typedef struct packed {
		logic [BYTE_W-1:0] dst_only;
		logic [BYTE_W-1:0] global_m;
		logic [BYTE_W-1:0] intra_zone;
		logic [BYTE_W-1:0] short_id;
	} mask_cfg_t;

	typedef struct packed {
		logic emit;
		logic complete;
		lay_t lay;
	} coll_stat_t;

	typedef struct packed {
		logic [LEN_W-1:0]  header_len;
		logic [BYTE_W-1:0] control_byte;
		logic [15:0]       src_asn;
		logic [15:0]       src_region;
		logic [15:0]       src_station;
		logic [31:0]       src_id;
		logic [15:0]       dst_asn;
		logic [15:0]       dst_region;
		logic [15:0]       dst_station;
		logic [31:0]       dst_id;
		logic              short_id_flag;
		logic              dst_only_flag;
	} hdr_res_t;

	// Masks are tested in priority order; no match falls back to local layout
	function automatic lay_t pick_layout(logic [BYTE_W-1:0] c, mask_cfg_t m);
		lay_t l;
		if ((c & m.dst_only) != '0) begin
			l = LAY_DST_ONLY;
		end else if ((c & m.global_m) != '0) begin
			l = LAY_GLOBAL;
		end else if ((c & m.intra_zone) != '0) begin
			l = ((c & m.short_id) != '0) ? LAY_SHORT : LAY_FULL;
		end else begin
			l = LAY_LOCAL;
		end
		return l;
	endfunction

	function automatic logic [LEN_W-1:0] body_len(lay_t l);
		logic [LEN_W-1:0] n;
		case (l)
			LAY_DST_ONLY: n = BODY_DST_ONLY;
			LAY_GLOBAL:   n = BODY_GLOBAL;
			LAY_FULL:     n = BODY_FULL;
			default:      n = BODY_SHORT;
		endcase
		return n;
	endfunction

endpackage

// ----- hdl/mhp_collect.sv -----
`timescale 1ns / 1ps

module mhp_collect (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  proc,
	input  logic [7:0]            data_s1,
	input  logic                  last_s1,
	input  mhp_pkg::mask_cfg_t    masks,
	output mhp_pkg::coll_stat_t   stat,
	output logic [7:0]            ctrl,
	output mhp_pkg::body_t        body_view
);
	import mhp_pkg::*;

	logic [LEN_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  cnt_next;
	logic [LEN_W-1:0]  widx;
	logic [LEN_W-1:0]  need;
	logic [BYTE_W-1:0] ctrl_q;
	logic              done_q;
	logic              active;
	body_t             body_q;
	lay_t              lay;

	assign active = !done_q;
	assign widx   = cnt_q - 5'd1;
	assign ctrl   = (cnt_q == '0) ? data_s1 : ctrl_q;

	always_comb begin
		if (cnt_q == '0) begin
			cnt_next = 5'd1;
		end else if (cnt_q < MAX_COUNT) begin
			cnt_next = cnt_q + 5'd1;
		end else begin
			cnt_next = cnt_q;
		end
	end

	// stored body with the current byte merged in at its write slot
	always_comb begin
		body_view = body_q;
		for (int i = 0; i < BODY_DEPTH; i++) begin
			if (cnt_q != '0 && widx == LEN_W'(i)) begin
				body_view[i] = data_s1;
			end
		end
	end

	// layout is re-evaluated every byte from the live mask registers
	assign lay           = pick_layout(ctrl, masks);
	assign need          = body_len(lay) + 5'd1;
	assign stat.lay      = lay;
	assign stat.complete = active && (cnt_next >= need);
	assign stat.emit     = active && ((cnt_next >= need) || last_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ctrl_q <= '0;
			done_q <= 1'b0;
		end else if (proc) begin
			if (active) begin
				ctrl_q <= ctrl;
			end
			if (last_s1) begin
				cnt_q  <= '0;
				done_q <= 1'b0;
			end else if (active) begin
				cnt_q  <= cnt_next;
				done_q <= stat.complete;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc && active && cnt_q != '0) begin
			body_q <= body_view;
		end
	end

endmodule

// ----- hdl/mhp_decode.sv -----
`timescale 1ns / 1ps

module mhp_decode (
	input  mhp_pkg::lay_t     lay,
	input  logic              complete,
	input  logic [7:0]        ctrl,
	input  mhp_pkg::body_t    body,
	output mhp_pkg::hdr_res_t res
);
	import mhp_pkg::*;

	function automatic logic [15:0] g16(body_t b, int i);
		logic [4:0] k;
		k = 5'(i);
		return {b[k], b[k+5'd1]};
	endfunction

	function automatic logic [31:0] g32(body_t b, int i);
		return {g16(b, i), g16(b, i + 2)};
	endfunction

	always_comb begin
		res              = '0;
		res.control_byte = ctrl;
		// short packet: everything but the control byte stays zero
		if (complete) begin
			res.header_len = body_len(lay) + 5'd1;
			case (lay)
				LAY_DST_ONLY: begin
					res.dst_id        = {16'd0, g16(body, 0)};
					res.short_id_flag = 1'b1;
					res.dst_only_flag = 1'b1;
				end
				LAY_GLOBAL: begin
					res.src_asn     = g16(body, 0);
					res.src_region  = g16(body, 2);
					res.src_station = g16(body, 4);
					res.src_id      = g32(body, 6);
					res.dst_asn     = g16(body, 10);
					res.dst_region  = g16(body, 12);
					res.dst_station = g16(body, 14);
					res.dst_id      = g32(body, 16);
				end
				LAY_SHORT: begin
					res.src_station   = g16(body, 0);
					res.dst_station   = g16(body, 2);
					res.src_id        = {16'd0, g16(body, 4)};
					res.dst_id        = {16'd0, g16(body, 6)};
					res.short_id_flag = 1'b1;
				end
				LAY_FULL: begin
					res.src_station = g16(body, 0);
					res.dst_station = g16(body, 2);
					res.src_id      = g32(body, 4);
					res.dst_id      = g32(body, 8);
				end
				default: begin
					// local layout: destination id first
					res.dst_id = g32(body, 0);
					res.src_id = g32(body, 4);
				end
			endcase
		end
	end

endmodule

// ----- hdl/mesh_header_parser_unit.sv -----
`timescale 1ns / 1ps
// Mesh packet header parser.
// Input channel (in_valid / in_stall): one packet byte per request, with
// last_byte marking the final byte of the packet. The first byte of a packet
// is the control byte; its bits against the four mask registers pick the
// header layout (3, 9, 13 or 21 bytes).
// Output channel (out_valid / out_stall): one request per packet, carrying all
// decoded header fields, or header_len 0 if the packet ended early. Bytes after
// a complete header produce nothing.
// A byte is first captured in the input register, then processed into the
// output register. Throughput is one byte per cycle while in_stall is low,
// set by the input register and the byte counter update.
// The output register lets the next byte be processed while a result waits;
// a stalled receiver only backs up the input when a new result is due.
// Config: cfg_we writes cfg_data into mask register cfg_index (0..3); other
// indexes are ignored. Write only while the block is idle.
// Reset: masks return to 1, 2, 4, 8; counters clear, no request pending.
module mesh_header_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  header_len,
	output logic [7:0]  control_byte,
	output logic [15:0] src_asn,
	output logic [15:0] src_region,
	output logic [15:0] src_station,
	output logic [31:0] src_id,
	output logic [15:0] dst_asn,
	output logic [15:0] dst_region,
	output logic [15:0] dst_station,
	output logic [31:0] dst_id,
	output logic        short_id_flag,
	output logic        dst_only_flag
);
	import mhp_pkg::*;

	mask_cfg_t   masks_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        out_free;
	logic        go;
	logic        proc;
	coll_stat_t  stat;
	logic [7:0]  ctrl;
	body_t       body_view;
	hdr_res_t    res;
	hdr_res_t    res_q;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_q.dst_only   <= 8'd1;
			masks_q.global_m   <= 8'd2;
			masks_q.intra_zone <= 8'd4;
			masks_q.short_id   <= 8'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DST_ONLY:   masks_q.dst_only   <= cfg_data;
				CFG_GLOBAL:     masks_q.global_m   <= cfg_data;
				CFG_INTRA_ZONE: masks_q.intra_zone <= cfg_data;
				CFG_SHORT_ID:   masks_q.short_id   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign go       = !stat.emit || out_free;
	assign proc     = valid_s1 && go;
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	mhp_collect u_collect (
		.clk       (clk),
		.arst_n    (arst_n),
		.proc      (proc),
		.data_s1   (data_s1),
		.last_s1   (last_s1),
		.masks     (masks_q),
		.stat      (stat),
		.ctrl      (ctrl),
		.body_view (body_view)
	);

	mhp_decode u_decode (
		.lay      (stat.lay),
		.complete (stat.complete),
		.ctrl     (ctrl),
		.body     (body_view),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && stat.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && stat.emit) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign header_len    = res_q.header_len;
	assign control_byte  = res_q.control_byte;
	assign src_asn       = res_q.src_asn;
	assign src_region    = res_q.src_region;
	assign src_station   = res_q.src_station;
	assign src_id        = res_q.src_id;
	assign dst_asn       = res_q.dst_asn;
	assign dst_region    = res_q.dst_region;
	assign dst_station   = res_q.dst_station;
	assign dst_id        = res_q.dst_id;
	assign short_id_flag = res_q.short_id_flag;
	assign dst_only_flag = res_q.dst_only_flag;

	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (header_len == 5'd0 || header_len == 5'd3 || header_len == 5'd9 ||
			header_len == 5'd13 || header_len == 5'd21))
		else $error("illegal header length");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_len == 5'd0 |-> !short_id_flag && !dst_only_flag &&
			src_id == 32'd0 && dst_id == 32'd0 && src_station == 16'd0)
		else $error("short packet result carries decoded fields");

	a_dst_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dst_only_flag |-> short_id_flag && header_len == 5'd3)
		else $error("destination-only result inconsistent");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && stat.emit && out_valid_q)
		else $error("input stalled without a pending result");

endmodule
